// ===== hw/rtl/bmf_pkg.sv =====
// Shared types, constants and helpers for the bounded message FIFO.
// Used by bmf_store, bmf_ctrl and bounded_message_fifo_core; no dependencies.
`timescale 1ns / 1ps

package bmf_pkg;

   // Sizing of the message store
   localparam int DEPTH     = 16;
   localparam int MSG_BYTES = 8;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   // Field widths fixed by the interface
   localparam int CMD_W    = 3;
   localparam int BYTES_W  = 4;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 3;
   localparam int QLEN_W   = 5;
   localparam int LIMIT_W  = 5;

   // Packed stream widths, rounded up to whole bytes
   localparam int REQ_DATA_W = ((BYTES_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BYTES_W + VALUE_W + QLEN_W + 3 + 7) / 8) * 8;

   // Limit after reset, saturated to the store depth
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'((16 > DEPTH) ? DEPTH : 16);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_SEND    = 3'd0,
      CMD_RECEIVE = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_DROP    = 3'd3,
      CMD_LOCK    = 3'd4,
      CMD_UNLOCK  = 3'd5,
      CMD_STATUS  = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_BAD_LEN    = 3'd1,
      ST_LOCKED     = 3'd2,
      ST_FULL       = 3'd3,
      ST_EMPTY      = 3'd4,
      ST_ALR_LOCKED = 3'd5,
      ST_NOT_LOCKED = 3'd6
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // One stored message
   typedef struct packed {
      logic [BYTES_W-1:0] nbytes;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // Access request from the controller to the store
   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      entry_type        wr_entry;
      logic             rd_en;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   // One result transaction
   typedef struct packed {
      status_type          status;
      logic [BYTES_W-1:0]  out_bytes;
      logic [VALUE_W-1:0]  out_value;
      logic [QLEN_W-1:0]   queue_length;
      logic                is_empty;
      logic                is_full;
      logic                is_locked;
   } rsp_type;

   // Advance a ring pointer, wrapping at the depth
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] nxt;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + PTR_W'(1);
      end
      return nxt;
   endfunction

endpackage

// ===== hw/rtl/bmf_store.sv =====
// Message store: one write port, one read port with registered read data.
// Depends on bmf_pkg for the entry type and depth.
`timescale 1ns / 1ps

module bmf_store (
   input  logic                clock,
   input  bmf_pkg::mem_req_type mem_req,
   output bmf_pkg::entry_type   rd_entry
);

   bmf_pkg::entry_type mem_ff [bmf_pkg::DEPTH];
   bmf_pkg::entry_type rd_entry_ff;

   // Write the tail entry on a push
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_entry;
      end
   end

   // Read the head entry into the registered read data
   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_entry_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== hw/rtl/bmf_ctrl.sv =====
// Command sequencer: pointers, count, lock, limit and the result register.
// Depends on bmf_pkg; drives the access requests of bmf_store.
`timescale 1ns / 1ps

module bmf_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  bmf_pkg::cmd_type               req_cmd,
   input  logic [bmf_pkg::BYTES_W-1:0]    req_bytes,
   input  logic [bmf_pkg::VALUE_W-1:0]    req_value,
   input  logic                           csr_we,
   input  logic [bmf_pkg::LIMIT_W-1:0]    csr_wdata,
   output bmf_pkg::mem_req_type           mem_req,
   input  bmf_pkg::entry_type             rd_entry,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output bmf_pkg::rsp_type               rsp
);

   bmf_pkg::fsm_type                state_ff, state_in;
   bmf_pkg::cmd_type                cmd_ff;
   logic [bmf_pkg::BYTES_W-1:0]     bytes_ff;
   logic [bmf_pkg::VALUE_W-1:0]     value_ff;
   logic [bmf_pkg::PTR_W-1:0]       head_ff, head_in;
   logic [bmf_pkg::PTR_W-1:0]       tail_ff, tail_in;
   logic [bmf_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            lock_ff, lock_in;
   logic [bmf_pkg::LIMIT_W-1:0]     limit_ff, limit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bmf_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            accept;
   logic                            exec_fire;
   logic                            do_push;
   logic                            do_pop;
   logic                            at_limit;
   bmf_pkg::status_type             status;

   assign accept = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmf_pkg::FSM_IDLE: begin
            if (req_valid) begin
               state_in = bmf_pkg::FSM_EXEC;
            end
         end
         bmf_pkg::FSM_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bmf_pkg::FSM_IDLE;
            end
         end
         default: state_in = bmf_pkg::FSM_IDLE;
      endcase
   end

   // State machine outputs
   always_comb begin
      req_ready = 1'b0;
      exec_fire = 1'b0;
      case (state_ff)
         bmf_pkg::FSM_IDLE: req_ready = 1'b1;
         bmf_pkg::FSM_EXEC: exec_fire = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            exec_fire = 1'b0;
         end
      endcase
   end

   // Decide the command against the current queue state
   always_comb begin
      status   = bmf_pkg::ST_OK;
      do_push  = 1'b0;
      do_pop   = 1'b0;
      lock_in  = lock_ff;
      at_limit = (32'(count_ff) >= 32'(limit_ff)) || (32'(count_ff) >= bmf_pkg::DEPTH);
      rsp_in   = rsp_ff;
      rsp_in.out_bytes = '0;
      rsp_in.out_value = '0;
      case (cmd_ff)
         bmf_pkg::CMD_SEND: begin
            if (bytes_ff == '0 || 32'(bytes_ff) > bmf_pkg::MSG_BYTES) begin
               status = bmf_pkg::ST_BAD_LEN;
            end else if (lock_ff) begin
               status = bmf_pkg::ST_LOCKED;
            end else if (at_limit) begin
               status = bmf_pkg::ST_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
         bmf_pkg::CMD_RECEIVE, bmf_pkg::CMD_PEEK, bmf_pkg::CMD_DROP: begin
            if (count_ff == '0) begin
               status = bmf_pkg::ST_EMPTY;
            end else begin
               if (cmd_ff != bmf_pkg::CMD_DROP) begin
                  rsp_in.out_bytes = rd_entry.nbytes;
                  rsp_in.out_value = rd_entry.value;
               end
               do_pop = (cmd_ff != bmf_pkg::CMD_PEEK);
            end
         end
         bmf_pkg::CMD_LOCK: begin
            if (lock_ff) begin
               status = bmf_pkg::ST_ALR_LOCKED;
            end else begin
               lock_in = 1'b1;
            end
         end
         bmf_pkg::CMD_UNLOCK: begin
            if (!lock_ff) begin
               status = bmf_pkg::ST_NOT_LOCKED;
            end else begin
               lock_in = 1'b0;
            end
         end
         default: status = bmf_pkg::ST_OK;
      endcase

      head_in  = do_pop  ? bmf_pkg::ptr_next(head_ff) : head_ff;
      tail_in  = do_push ? bmf_pkg::ptr_next(tail_ff) : tail_ff;
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + bmf_pkg::CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - bmf_pkg::CNT_W'(1);
      end

      rsp_in.status       = status;
      rsp_in.queue_length = bmf_pkg::QLEN_W'(count_in);
      rsp_in.is_empty     = (count_in == '0);
      rsp_in.is_full      = (32'(count_in) >= 32'(limit_ff));
      rsp_in.is_locked    = lock_in;
   end

   // Read the head on acceptance, write the tail when a send lands
   always_comb begin
      mem_req.rd_en           = accept;
      mem_req.rd_addr         = head_ff;
      mem_req.wr_en           = exec_fire && do_push;
      mem_req.wr_addr         = tail_ff;
      mem_req.wr_entry.nbytes = bytes_ff;
      mem_req.wr_entry.value  = value_ff;
   end

   // Saturate the limit to the store depth
   assign limit_in = (csr_wdata > bmf_pkg::LIMIT_MAX) ? bmf_pkg::LIMIT_MAX : csr_wdata;

   // Result valid: set on completion, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmf_pkg::FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         lock_ff      <= 1'b0;
         limit_ff     <= bmf_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= limit_in;
         end
         if (exec_fire) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            lock_ff  <= lock_in;
         end
      end
   end

   // Hold the command and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         bytes_ff <= req_bytes;
         value_ff <= req_value;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= bmf_pkg::DEPTH)
      else $error("message count exceeds store depth");

   // An empty queue has its pointers together
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("pointers apart on an empty queue");

   // A landed send grows the queue by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && do_push) |=> (count_ff == $past(count_ff) + bmf_pkg::CNT_W'(1)))
      else $error("send did not grow the queue");

   // A refused command returns no message
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != bmf_pkg::ST_OK)
         |-> (rsp_ff.out_bytes == '0 && rsp_ff.out_value == '0))
      else $error("refused command returned a message");

   // No new transaction is taken while one is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == bmf_pkg::FSM_EXEC && !req_ready))
      else $error("second transaction taken in flight");

endmodule

// ===== hw/rtl/bounded_message_fifo_core.sv =====
// Bounded message FIFO, top level: stream ports, controller and message store.
// Depends on bmf_pkg, bmf_ctrl and bmf_store.
`timescale 1ns / 1ps

// Each request transaction carries one command (send, receive, peek, drop,
// lock, unlock, status) and yields exactly one response transaction with
// the status code, the head message for receive and peek, and the queue
// length, empty, full and lock flags after the command. A command is taken in
// the idle state, where the head entry is read from the single-port-read
// message store; in the execute state the command is decided against that
// data and a send is written back. The next request is taken only back in
// idle; no command is taken before the last one is done. The response sits in
// an output register; while it is not taken the execute state stretches.
// Reset empties the queue, unlocks it and sets the limit to 16; no clearing
// pass is needed. csr_wdata above the depth saturates to the depth.
module bounded_message_fifo_core (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bmf_pkg::REQ_DATA_W-1:0]    req_tdata,  // message_bytes, message_value, pad
   input  logic [bmf_pkg::CMD_W-1:0]         req_tuser,  // cmd
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_bytes, out_value, queue_length, is_empty, is_full, is_locked, pad
   output logic [bmf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [bmf_pkg::STATUS_W-1:0]      rsp_tuser,  // status
   // limit register
   input  logic                              csr_we,
   input  logic [bmf_pkg::LIMIT_W-1:0]       csr_wdata
);

   localparam int RSP_USED_W = bmf_pkg::BYTES_W + bmf_pkg::VALUE_W + bmf_pkg::QLEN_W + 3;

   bmf_pkg::mem_req_type mem_req;
   bmf_pkg::entry_type   rd_entry;
   bmf_pkg::rsp_type     rsp;
   bmf_pkg::cmd_type     req_cmd;

   // Unpack the request
   assign req_cmd = bmf_pkg::cmd_type'(req_tuser);

   bmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_cmd),
      .req_bytes (req_tdata[bmf_pkg::BYTES_W-1:0]),
      .req_value (req_tdata[bmf_pkg::BYTES_W +: bmf_pkg::VALUE_W]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .mem_req   (mem_req),
      .rd_entry  (rd_entry),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   bmf_store u_store (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_entry (rd_entry)
   );

   // Pack the response, lowest field first
   assign rsp_tuser = rsp.status;
   assign rsp_tdata = bmf_pkg::RSP_DATA_W'({rsp.is_locked, rsp.is_full, rsp.is_empty,
                                            rsp.queue_length, rsp.out_value,
                                            rsp.out_bytes});

   // Widths of the packed response must line up
   a_rsp_pack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_USED_W-1] == rsp.is_locked))
      else $error("response packing misaligned");

   a_rsp_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[bmf_pkg::BYTES_W + bmf_pkg::VALUE_W +: bmf_pkg::QLEN_W]
                      == rsp.queue_length))
      else $error("response length field misaligned");

   a_rsp_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.is_empty == (rsp.queue_length == '0)))
      else $error("empty flag disagrees with length");

endmodule

// ===== test/bounded_message_fifo_core_tb.sv =====
// Self-checking testbench for bounded_message_fifo_core: directed and random command
// streams under random back-pressure, checked against an in-bench queue model.
// Depends on bmf_pkg and the bounded_message_fifo_core RTL.
`timescale 1ns / 1ps

module bounded_message_fifo_core_tb;

   localparam int TIMEOUT_CYCLES = 100000;
   localparam int PHASE_ITEMS    = 215;
   localparam int PHASE_COUNT    = 8;
   localparam int IDLE_PERCENT   = 16;

   // Command code outside the enum; the block treats it as status
   localparam logic [bmf_pkg::CMD_W-1:0] CMD_SPARE = 3'd7;

   // Response tdata layout, lowest bit first
   localparam int OB_LO     = 0;
   localparam int OV_LO     = OB_LO + bmf_pkg::BYTES_W;
   localparam int QL_LO     = OV_LO + bmf_pkg::VALUE_W;
   localparam int EMPTY_BIT = QL_LO + bmf_pkg::QLEN_W;
   localparam int FULL_BIT  = EMPTY_BIT + 1;
   localparam int LOCK_BIT  = EMPTY_BIT + 2;

   typedef struct packed {
      logic [bmf_pkg::CMD_W-1:0]   cmd;
      logic [bmf_pkg::BYTES_W-1:0] nbytes;
      logic [bmf_pkg::VALUE_W-1:0] value;
   } fifo_cmd_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bmf_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [bmf_pkg::CMD_W-1:0]        req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bmf_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [bmf_pkg::STATUS_W-1:0]     rsp_tuser;
   logic                             csr_we     = 1'b0;
   logic [bmf_pkg::LIMIT_W-1:0]      csr_wdata  = '0;

   // Stimulus and expectation stores
   fifo_cmd_type      pending_cmds [$];
   bmf_pkg::rsp_type  expected_responses [$];
   fifo_cmd_type      presented;
   int                cmds_queued       = 0;
   int                cmds_accepted     = 0;
   int                responses_checked = 0;
   int                mismatch_count    = 0;
   int                cycle_count       = 0;

   // Queue model state
   logic [bmf_pkg::VALUE_W-1:0] model_value [bmf_pkg::DEPTH];
   logic [bmf_pkg::BYTES_W-1:0] model_len [bmf_pkg::DEPTH];
   int unsigned                 model_head   = 0;
   int unsigned                 model_tail   = 0;
   int unsigned                 model_held   = 0;
   int unsigned                 model_limit  = 32'(bmf_pkg::LIMIT_RESET);
   bit                          model_locked = 1'b0;

   bounded_message_fifo_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Apply one command to the queue model and return the response it should give
   function automatic bmf_pkg::rsp_type predict_response(input fifo_cmd_type c);
      bmf_pkg::rsp_type r;
      r = '0;
      r.status = bmf_pkg::ST_OK;
      case (c.cmd)
         bmf_pkg::CMD_SEND: begin
            // length is checked before the lock, the lock before the limit
            if (c.nbytes == 0 || c.nbytes > bmf_pkg::MSG_BYTES) begin
               r.status = bmf_pkg::ST_BAD_LEN;
            end else if (model_locked) begin
               r.status = bmf_pkg::ST_LOCKED;
            end else if (model_held >= model_limit || model_held >= bmf_pkg::DEPTH) begin
               r.status = bmf_pkg::ST_FULL;
            end else begin
               model_value[model_tail] = c.value;
               model_len[model_tail] = c.nbytes;
               model_tail = (model_tail + 1) % bmf_pkg::DEPTH;
               model_held++;
            end
         end
         bmf_pkg::CMD_RECEIVE, bmf_pkg::CMD_PEEK, bmf_pkg::CMD_DROP: begin
            if (model_held == 0) begin
               r.status = bmf_pkg::ST_EMPTY;
            end else begin
               if (c.cmd != bmf_pkg::CMD_DROP) begin
                  r.out_bytes = model_len[model_head];
                  r.out_value = model_value[model_head];
               end
               if (c.cmd != bmf_pkg::CMD_PEEK) begin
                  model_head = (model_head + 1) % bmf_pkg::DEPTH;
                  model_held--;
               end
            end
         end
         bmf_pkg::CMD_LOCK: begin
            if (model_locked) begin
               r.status = bmf_pkg::ST_ALR_LOCKED;
            end else begin
               model_locked = 1'b1;
            end
         end
         bmf_pkg::CMD_UNLOCK: begin
            if (!model_locked) begin
               r.status = bmf_pkg::ST_NOT_LOCKED;
            end else begin
               model_locked = 1'b0;
            end
         end
         default: begin
         end
      endcase
      r.queue_length = bmf_pkg::QLEN_W'(model_held);
      r.is_empty     = (model_held == 0);
      r.is_full      = (model_held >= model_limit);
      r.is_locked    = model_locked;
      return r;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [bmf_pkg::VALUE_W-1:0] got,
                                  input logic [bmf_pkg::VALUE_W-1:0] want);
      mismatch_count++;
      $display("ERROR: response %0d %s: got 0x%0h, expected 0x%0h at %0t",
               responses_checked, what, got, want, $realtime);
   endtask

   // Compare the response on the bus with the oldest expectation
   task automatic check_response();
      bmf_pkg::rsp_type want;
      if (expected_responses.size() == 0) begin
         report_mismatch("arrived with no command outstanding",
                         rsp_tdata[bmf_pkg::VALUE_W-1:0], '0);
         return;
      end
      want = expected_responses.pop_front();
      if (rsp_tuser !== want.status)
         report_mismatch("status", bmf_pkg::VALUE_W'(rsp_tuser),
                         bmf_pkg::VALUE_W'(want.status));
      if (rsp_tdata[OB_LO +: bmf_pkg::BYTES_W] !== want.out_bytes)
         report_mismatch("out_bytes", bmf_pkg::VALUE_W'(rsp_tdata[OB_LO +: bmf_pkg::BYTES_W]),
                         bmf_pkg::VALUE_W'(want.out_bytes));
      if (rsp_tdata[OV_LO +: bmf_pkg::VALUE_W] !== want.out_value)
         report_mismatch("out_value", rsp_tdata[OV_LO +: bmf_pkg::VALUE_W], want.out_value);
      if (rsp_tdata[QL_LO +: bmf_pkg::QLEN_W] !== want.queue_length)
         report_mismatch("queue_length", bmf_pkg::VALUE_W'(rsp_tdata[QL_LO +: bmf_pkg::QLEN_W]),
                         bmf_pkg::VALUE_W'(want.queue_length));
      if (rsp_tdata[EMPTY_BIT] !== want.is_empty)
         report_mismatch("is_empty", bmf_pkg::VALUE_W'(rsp_tdata[EMPTY_BIT]),
                         bmf_pkg::VALUE_W'(want.is_empty));
      if (rsp_tdata[FULL_BIT] !== want.is_full)
         report_mismatch("is_full", bmf_pkg::VALUE_W'(rsp_tdata[FULL_BIT]),
                         bmf_pkg::VALUE_W'(want.is_full));
      if (rsp_tdata[LOCK_BIT] !== want.is_locked)
         report_mismatch("is_locked", bmf_pkg::VALUE_W'(rsp_tdata[LOCK_BIT]),
                         bmf_pkg::VALUE_W'(want.is_locked));
   endtask

   // Request driver: predict on each accepted transaction, then load the next command
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(predict_response(presented));
            cmds_accepted <= cmds_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() != 0 &&
                ((cmds_accepted >= 700 && cmds_accepted < 1000) ||
                 $urandom_range(99) >= IDLE_PERCENT)) begin
               presented = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= bmf_pkg::REQ_DATA_W'({presented.value, presented.nbytes});
               req_tuser  <= presented.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each accepted transaction, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_response();
            responses_checked <= responses_checked + 1;
         end
         rsp_tready <= (responses_checked >= 700 && responses_checked < 1000) ||
                       ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [bmf_pkg::VALUE_W-1:0] random_payload();
      int pick;
      pick = $urandom_range(15);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic queue_cmd(input logic [bmf_pkg::CMD_W-1:0] cmd, input int nbytes,
                            input logic [bmf_pkg::VALUE_W-1:0] value);
      fifo_cmd_type c;
      c.cmd    = cmd;
      c.nbytes = bmf_pkg::BYTES_W'(nbytes);
      c.value  = value;
      pending_cmds.push_back(c);
      cmds_queued++;
   endtask

   // Draw one command; fill bursts favour sends, drain bursts favour removals
   task automatic queue_random_cmd(input bit fill);
      int r;
      int k;
      logic [bmf_pkg::VALUE_W-1:0] junk;
      r = $urandom_range(99);
      k = $urandom_range(99);
      junk = random_payload();
      if (r < (fill ? 55 : 22))
         queue_cmd(bmf_pkg::CMD_SEND, $urandom_range(bmf_pkg::MSG_BYTES, 1), junk);
      else if (k < 40)
         queue_cmd(bmf_pkg::CMD_RECEIVE, $urandom_range(15), junk);
      else if (k < 52)
         queue_cmd(bmf_pkg::CMD_PEEK, $urandom_range(15), junk);
      else if (k < 68)
         queue_cmd(bmf_pkg::CMD_DROP, $urandom_range(15), junk);
      else if (k < 72)
         queue_cmd(bmf_pkg::CMD_LOCK, $urandom_range(15), junk);
      else if (k < 84)
         queue_cmd(bmf_pkg::CMD_UNLOCK, $urandom_range(15), junk);
      else if (k < 90)
         queue_cmd(bmf_pkg::CMD_STATUS, $urandom_range(15), junk);
      else if (k < 96)
         queue_cmd(bmf_pkg::CMD_SEND,
                   $urandom_range(1) ? 0 : $urandom_range(15, bmf_pkg::MSG_BYTES + 1), junk);
      else
         queue_cmd(CMD_SPARE, $urandom_range(15), junk);
   endtask

   // Hold until every queued command has been answered
   task automatic wait_until_idle();
      while (cmds_accepted != cmds_queued || responses_checked != cmds_accepted)
         @(posedge clock);
   endtask

   task automatic write_limit(input int unsigned v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= bmf_pkg::LIMIT_W'(v);
      model_limit = (v > bmf_pkg::DEPTH) ? bmf_pkg::DEPTH : v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned lim;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty queue, unlock when not locked, length extremes, lock scope and order
      queue_cmd(bmf_pkg::CMD_STATUS, 0, '0);
      queue_cmd(bmf_pkg::CMD_RECEIVE, 15, '1);
      queue_cmd(bmf_pkg::CMD_PEEK, 0, '0);
      queue_cmd(bmf_pkg::CMD_DROP, 0, '0);
      queue_cmd(bmf_pkg::CMD_UNLOCK, 0, '0);
      queue_cmd(bmf_pkg::CMD_SEND, 0, random_payload());
      queue_cmd(bmf_pkg::CMD_SEND, 15, random_payload());
      queue_cmd(bmf_pkg::CMD_SEND, bmf_pkg::MSG_BYTES + 1, random_payload());
      queue_cmd(bmf_pkg::CMD_SEND, bmf_pkg::MSG_BYTES, '1);
      queue_cmd(bmf_pkg::CMD_SEND, 1, '0);
      queue_cmd(bmf_pkg::CMD_PEEK, 0, '0);
      queue_cmd(bmf_pkg::CMD_LOCK, 0, '0);
      queue_cmd(bmf_pkg::CMD_LOCK, 0, '0);
      queue_cmd(bmf_pkg::CMD_SEND, 0, random_payload());
      queue_cmd(bmf_pkg::CMD_SEND, 3, random_payload());
      queue_cmd(bmf_pkg::CMD_RECEIVE, 0, '0);
      queue_cmd(bmf_pkg::CMD_UNLOCK, 0, '0);
      queue_cmd(CMD_SPARE, 0, '0);
      queue_cmd(bmf_pkg::CMD_DROP, 0, '0);
      wait_until_idle();

      // Small limit: reach full, then length and lock ahead of full
      write_limit(2);
      queue_cmd(bmf_pkg::CMD_SEND, 5, {$urandom, $urandom});
      queue_cmd(bmf_pkg::CMD_SEND, 2, {$urandom, $urandom});
      queue_cmd(bmf_pkg::CMD_SEND, 4, {$urandom, $urandom});
      queue_cmd(bmf_pkg::CMD_SEND, 0, {$urandom, $urandom});
      queue_cmd(bmf_pkg::CMD_LOCK, 0, '0);
      queue_cmd(bmf_pkg::CMD_SEND, 4, {$urandom, $urandom});
      queue_cmd(bmf_pkg::CMD_UNLOCK, 0, '0);
      wait_until_idle();

      // Random phases; the first limit sits below the current count
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: lim = 1;
            1: lim = 16;
            2: lim = 31;
            3: lim = 0;
            4: lim = 7;
            5: lim = 20;
            6: lim = 3;
            default: lim = $urandom_range(31);
         endcase
         write_limit(lim);
         for (int n = 0; n < PHASE_ITEMS; n++)
            queue_random_cmd(((n / 16) % 2) == 0);
         wait_until_idle();
      end

      repeat (20) @(posedge clock);
      if (expected_responses.size() != 0)
         report_mismatch("responses still outstanding",
                         bmf_pkg::VALUE_W'(expected_responses.size()), '0);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_store.sv
hw/rtl/bmf_ctrl.sv
hw/rtl/bounded_message_fifo_core.sv
test/bounded_message_fifo_core_tb.sv
